// ===== sv/lmgb_pkg.sv =====
// Package for the local mean glare binarizer.
// Holds the sequencer state type, the divider control struct, the fixed threshold constants and the register indices.
// No dependencies.
package lmgb_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_SUM_END,
    S_DIV,
    S_THR,
    S_DARK,
    S_DARK_END,
    S_DONE
  } lmgb_state_t;

  typedef struct packed {
    logic start;
    logic done;
  } lmgb_div_ctl_t;

  localparam logic [7:0] THR_LOW     = 8'd30;
  localparam logic [7:0] THR_HIGH    = 8'd220;
  localparam logic [8:0] WHITE_GAP   = 9'd30;
  localparam logic [7:0] GLARE_LEVEL = 8'd220;
  localparam logic [3:0] DARK_VOTES  = 4'd4;
  localparam logic [0:0] REG_MARGIN  = 1'b0;
  localparam logic [0:0] REG_OFFSET  = 1'b1;

endpackage

// ===== sv/lmgb_divider.sv =====
// Reciprocal-multiply divider for the window sum by the window area, result registered in the cycle after start.
// Used by the binarizer; the area is one of the three window sizes (3x3, 5x5, 7x7).
// Depends on lmgb_pkg for the control struct.
module lmgb_divider #(
  parameter int NW = 14,
  parameter int DW = 6
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lmgb_pkg::lmgb_div_ctl_t ctl_in,
  output lmgb_pkg::lmgb_div_ctl_t ctl_out,
  input  logic [NW-1:0]          dividend,
  input  logic [DW-1:0]          divisor,
  output logic [NW-1:0]          quotient
);

  localparam int K   = NW + DW;
  localparam int RCW = K - 2;
  localparam int PW  = NW + RCW;
  localparam logic [DW-1:0]  AREA_3  = DW'(9);
  localparam logic [DW-1:0]  AREA_5  = DW'(25);
  localparam logic [DW-1:0]  AREA_7  = DW'(49);
  localparam logic [RCW-1:0] RECIP_3 = RCW'(((64'd1 << K) + 64'd8) / 64'd9);
  localparam logic [RCW-1:0] RECIP_5 = RCW'(((64'd1 << K) + 64'd24) / 64'd25);
  localparam logic [RCW-1:0] RECIP_7 = RCW'(((64'd1 << K) + 64'd48) / 64'd49);

  logic [RCW-1:0] recip;
  logic [PW-1:0]  prod;
  logic [NW-1:0]  quo_r, quo_nxt;
  logic           done_r, done_nxt;

  always_comb begin
    unique case (divisor)
      AREA_3:  recip = RECIP_3;
      AREA_5:  recip = RECIP_5;
      AREA_7:  recip = RECIP_7;
      default: recip = '0;
    endcase
    prod     = PW'(dividend) * PW'(recip);
    quo_nxt  = ctl_in.start ? NW'(prod >> K) : quo_r;
    done_nxt = ctl_in.start;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
  end

  assign ctl_out.start = 1'b0;
  assign ctl_out.done  = done_r;
  assign quotient      = quo_r;

`ifndef SYNTHESIS
  a_done_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(ctl_in.start)) else $error("divider done without start");
  a_area_known: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_in.start |-> (divisor == AREA_3 || divisor == AREA_5 || divisor == AREA_7))
    else $error("unknown window area");
  a_quot_exact: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ((PW'(quo_r) * PW'($past(divisor)) <= PW'($past(dividend)))
             && ((PW'(quo_r) + PW'(1)) * PW'($past(divisor)) > PW'($past(dividend)))))
    else $error("quotient not exact");
`endif

endmodule

// ===== sv/local_mean_glare_binarizer.sv =====
// Local mean glare binarizer: line store in one memory, window walked one pixel a cycle.
// An interior item (m = margin) walks its (2m+1)x(2m+1) window and then the 3x3 block through
// the single memory read port; other pixels are only stored.
// The result is valid in the cycle in which the next item can be taken; a waiting result
// holds the block. Reset: synchronous, active low, clears counters, config (margin 1,
// offset 0) and control; the line store is not cleared.
module local_mean_glare_binarizer #(
  parameter int IMAGE_WIDTH  = 128,
  parameter int IMAGE_HEIGHT = 64,
  parameter int MAX_MARGIN   = 3
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_pixel,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [5:0] out_row,
  output logic [6:0] out_col,
  output logic       out_is_white,
  output logic       out_frame_last,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [8:0] cfg_data
);

  localparam int S    = 2 * MAX_MARGIN + 1;
  localparam int RW   = $clog2(IMAGE_HEIGHT);
  localparam int CW   = $clog2(IMAGE_WIDTH);
  localparam int SLW  = $clog2(S + 1);
  localparam int AW   = $clog2(S * IMAGE_WIDTH);
  localparam int MW   = $clog2(MAX_MARGIN + 1);
  localparam int SDW  = $clog2(S + 1);
  localparam int DVW  = $clog2(S * S + 1);
  localparam int SUMW = $clog2(S * S * 255 + 1);

  logic [7:0] mem [S*IMAGE_WIDTH];
  logic [7:0] rdata_r;
  logic [AW-1:0] waddr, raddr;

  lmgb_pkg::lmgb_state_t state_r, state_nxt;
  logic [1:0]       wm_r, wm_nxt;
  logic [8:0]       off_r, off_nxt;
  logic [RW-1:0]    row_r, row_nxt;
  logic [CW-1:0]    col_r, col_nxt;
  logic [SLW-1:0]   slot_r, slot_nxt;
  logic [RW-1:0]    cr_r, cr_nxt;
  logic [CW-1:0]    cc_r, cc_nxt;
  logic [CW-1:0]    cbase_r, cbase_nxt;
  logic [SLW-1:0]   rs_r, rs_nxt;
  logic [SLW-1:0]   dslot_r, dslot_nxt;
  logic [SDW-1:0]   side_r, side_nxt;
  logic [SDW-1:0]   ri_r, ri_nxt;
  logic [SDW-1:0]   j_r, j_nxt;
  logic [MW-1:0]    mg_r, mg_nxt;
  logic             last_r, last_nxt;
  logic [SUMW-1:0]  sum_r, sum_nxt;
  logic             rd_sum_r, rd_sum_nxt;
  logic             rd_dark_r, rd_dark_nxt;
  logic             rd_cen_r, rd_cen_nxt;
  logic [3:0]       dark_r, dark_nxt;
  logic [7:0]       cen_r, cen_nxt;
  logic [7:0]       thr_r, thr_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [5:0]       orow_r, orow_nxt;
  logic [6:0]       ocol_r, ocol_nxt;
  logic             owhite_r, owhite_nxt;
  logic             olast_r, olast_nxt;

  logic [MW-1:0]    m_eff;
  logic             in_acc;
  logic             mem_rd;
  logic [SLW:0]     slot_t, dslot_t;
  logic [SUMW-1:0]  sum_add;
  logic [SUMW-1:0]  quotient;
  logic signed [10:0] diff;
  logic             white;
  lmgb_pkg::lmgb_div_ctl_t div_ci, div_co;

  lmgb_divider #(.NW(SUMW), .DW(DVW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_in   (div_ci),
    .ctl_out  (div_co),
    .dividend (sum_add),
    .divisor  (DVW'(side_r * side_r)),
    .quotient (quotient)
  );

  always_comb begin
    if (wm_r == 2'd0) begin
      m_eff = MW'(1);
    end else if (int'(wm_r) > MAX_MARGIN) begin
      m_eff = MW'(MAX_MARGIN);
    end else begin
      m_eff = MW'(wm_r);
    end
  end

  assign in_acc  = in_valid && in_ready;
  assign in_ready = (state_r == lmgb_pkg::S_IDLE);
  assign waddr   = AW'(int'(slot_r) * IMAGE_WIDTH + int'(col_r));
  assign raddr   = AW'(int'(rs_r) * IMAGE_WIDTH + int'(cbase_r) + int'(j_r));
  assign sum_add = sum_r + (rd_sum_r ? SUMW'(rdata_r) : SUMW'(0));
  assign diff    = $signed({3'b000, quotient[7:0]}) - $signed({{2{off_r[8]}}, off_r});
  assign white   = (cen_r > lmgb_pkg::GLARE_LEVEL) ? (dark_r < lmgb_pkg::DARK_VOTES)
                 : ({1'b0, cen_r} > ({1'b0, thr_r} + lmgb_pkg::WHITE_GAP));

  always_comb begin
    state_nxt     = state_r;
    wm_nxt        = wm_r;
    off_nxt       = off_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    slot_nxt      = slot_r;
    cr_nxt        = cr_r;
    cc_nxt        = cc_r;
    cbase_nxt     = cbase_r;
    rs_nxt        = rs_r;
    dslot_nxt     = dslot_r;
    side_nxt      = side_r;
    ri_nxt        = ri_r;
    j_nxt         = j_r;
    mg_nxt        = mg_r;
    last_nxt      = last_r;
    sum_nxt       = sum_add;
    rd_sum_nxt    = 1'b0;
    rd_dark_nxt   = 1'b0;
    rd_cen_nxt    = 1'b0;
    dark_nxt      = dark_r;
    cen_nxt       = rd_cen_r ? rdata_r : cen_r;
    thr_nxt       = thr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    orow_nxt      = orow_r;
    ocol_nxt      = ocol_r;
    owhite_nxt    = owhite_r;
    olast_nxt     = olast_r;
    mem_rd        = 1'b0;
    div_ci.start  = 1'b0;
    div_ci.done   = 1'b0;
    slot_t        = {1'b0, slot_r} + (SLW+1)'(S) - (SLW+1)'({m_eff, 1'b0});
    dslot_t       = '0;

    if (rd_dark_r && (rdata_r < thr_r)) begin
      dark_nxt = dark_r + 1'b1;
    end

    if (cfg_we) begin
      unique case (cfg_index)
        lmgb_pkg::REG_MARGIN: wm_nxt  = cfg_data[1:0];
        lmgb_pkg::REG_OFFSET: off_nxt = cfg_data;
        default: ;
      endcase
    end

    unique case (state_r)
      lmgb_pkg::S_IDLE: begin
        if (in_acc) begin
          if (col_r == CW'(IMAGE_WIDTH - 1)) begin
            col_nxt = '0;
            if (row_r == RW'(IMAGE_HEIGHT - 1)) begin
              row_nxt  = '0;
              slot_nxt = '0;
            end else begin
              row_nxt  = row_r + 1'b1;
              slot_nxt = (slot_r == SLW'(S - 1)) ? SLW'(0) : slot_r + 1'b1;
            end
          end else begin
            col_nxt = col_r + 1'b1;
          end
          if ((int'(row_r) >= 2 * int'(m_eff)) && (int'(col_r) >= 2 * int'(m_eff))) begin
            cr_nxt    = row_r - RW'(m_eff);
            cc_nxt    = col_r - CW'(m_eff);
            cbase_nxt = col_r - CW'({m_eff, 1'b0});
            rs_nxt    = (slot_t >= (SLW+1)'(S)) ? SLW'(slot_t - (SLW+1)'(S)) : SLW'(slot_t);
            dslot_t   = {1'b0, slot_r} + (SLW+1)'(S) - (SLW+1)'(m_eff) - (SLW+1)'(1);
            dslot_nxt = (dslot_t >= (SLW+1)'(S)) ? SLW'(dslot_t - (SLW+1)'(S))
                      : SLW'(dslot_t);
            side_nxt  = SDW'({m_eff, 1'b1});
            mg_nxt    = m_eff;
            ri_nxt    = '0;
            j_nxt     = '0;
            sum_nxt   = '0;
            dark_nxt  = '0;
            last_nxt  = (row_r == RW'(IMAGE_HEIGHT - 1)) && (col_r == CW'(IMAGE_WIDTH - 1));
            state_nxt = lmgb_pkg::S_SUM;
          end
        end
      end
      lmgb_pkg::S_SUM, lmgb_pkg::S_DARK: begin
        mem_rd = 1'b1;
        if (state_r == lmgb_pkg::S_SUM) begin
          rd_sum_nxt = 1'b1;
        end else begin
          rd_dark_nxt = 1'b1;
          rd_cen_nxt  = (ri_r == SDW'(1)) && (j_r == SDW'(1));
        end
        if (j_r == side_r - 1'b1) begin
          j_nxt  = '0;
          ri_nxt = ri_r + 1'b1;
          rs_nxt = (rs_r == SLW'(S - 1)) ? SLW'(0) : rs_r + 1'b1;
          if (ri_r == side_r - 1'b1) begin
            state_nxt = (state_r == lmgb_pkg::S_SUM) ? lmgb_pkg::S_SUM_END
                      : lmgb_pkg::S_DARK_END;
          end
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      lmgb_pkg::S_SUM_END: begin
        div_ci.start = 1'b1;
        state_nxt    = lmgb_pkg::S_DIV;
      end
      lmgb_pkg::S_DIV: begin
        if (div_co.done) begin
          state_nxt = lmgb_pkg::S_THR;
        end
      end
      lmgb_pkg::S_THR: begin
        if (diff < 11'sd30) begin
          thr_nxt = lmgb_pkg::THR_LOW;
        end else if (diff > 11'sd220) begin
          thr_nxt = lmgb_pkg::THR_HIGH;
        end else begin
          thr_nxt = diff[7:0];
        end
        rs_nxt    = dslot_r;
        cbase_nxt = cc_r - 1'b1;
        side_nxt  = SDW'(3);
        ri_nxt    = '0;
        j_nxt     = '0;
        dark_nxt  = '0;
        state_nxt = lmgb_pkg::S_DARK;
      end
      lmgb_pkg::S_DARK_END: begin
        state_nxt = lmgb_pkg::S_DONE;
      end
      lmgb_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          orow_nxt      = 6'(cr_r);
          ocol_nxt      = 7'(cc_r);
          owhite_nxt    = white;
          olast_nxt     = last_r;
          state_nxt     = lmgb_pkg::S_IDLE;
        end
      end
      default: state_nxt = lmgb_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mem[waddr] <= in_pixel;
    end
    if (mem_rd) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lmgb_pkg::S_IDLE;
      wm_r        <= 2'd1;
      off_r       <= '0;
      row_r       <= '0;
      col_r       <= '0;
      slot_r      <= '0;
      rd_sum_r    <= 1'b0;
      rd_dark_r   <= 1'b0;
      rd_cen_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wm_r        <= wm_nxt;
      off_r       <= off_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      slot_r      <= slot_nxt;
      rd_sum_r    <= rd_sum_nxt;
      rd_dark_r   <= rd_dark_nxt;
      rd_cen_r    <= rd_cen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cr_r     <= cr_nxt;
    cc_r     <= cc_nxt;
    cbase_r  <= cbase_nxt;
    rs_r     <= rs_nxt;
    dslot_r  <= dslot_nxt;
    side_r   <= side_nxt;
    ri_r     <= ri_nxt;
    j_r      <= j_nxt;
    mg_r     <= mg_nxt;
    last_r   <= last_nxt;
    sum_r    <= sum_nxt;
    dark_r   <= dark_nxt;
    cen_r    <= cen_nxt;
    thr_r    <= thr_nxt;
    orow_r   <= orow_nxt;
    ocol_r   <= ocol_nxt;
    owhite_r <= owhite_nxt;
    olast_r  <= olast_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_row        = orow_r;
  assign out_col        = ocol_r;
  assign out_is_white   = owhite_r;
  assign out_frame_last = olast_r;

`ifndef SYNTHESIS
  a_quot_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lmgb_pkg::S_THR) |-> (quotient <= SUMW'(255)))
    else $error("window mean above 255");
  a_dark_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lmgb_pkg::S_DONE) |-> (dark_r <= 4'd9))
    else $error("dark count above nine");
  a_thr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lmgb_pkg::S_DARK) |-> (thr_r >= lmgb_pkg::THR_LOW && thr_r <= lmgb_pkg::THR_HIGH))
    else $error("threshold out of range");
  a_margin_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lmgb_pkg::S_SUM) |-> (side_r == SDW'({mg_r, 1'b1})))
    else $error("window side lost");
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lmgb_pkg::S_DONE && (!out_valid_r || out_ready)) |=> out_valid_r)
    else $error("result not loaded");
`endif

endmodule

// ===== bench/tb_local_mean_glare_binarizer.sv =====
// Self-checking bench for local_mean_glare_binarizer: directed pixels, then random grey pixels at several
// window margins and offsets, each item predicted in the bench and compared per field.
// Depends on lmgb_pkg and the block itself.
module tb_local_mean_glare_binarizer;

  localparam int WIDTH = 128;
  localparam int HEIGHT = 64;
  localparam int SLOTS = 7;
  localparam int STALL_LIMIT = 5000;

  typedef struct {
    logic [5:0] row;
    logic [6:0] col;
    logic       white;
    logic       last;
  } mark_t;

  class glare_mark_board;
    logic [7:0] lines [SLOTS*WIDTH];
    int         row_pos;
    int         col_pos;
    logic [1:0] margin;
    logic [8:0] offset;
    mark_t      pending [$];
    int         errors;

    function new();
      foreach (lines[i]) lines[i] = 8'd0;
      row_pos = 0;
      col_pos = 0;
      margin = 2'd1;
      offset = 9'd0;
      errors = 0;
    endfunction

    function int pix(int r, int c);
      return lines[(r % SLOTS) * WIDTH + c];
    endfunction

    function void note_pixel(logic [7:0] p);
      int m, cr, cc, side, sum, thr, centre, dark;
      bit white;
      mark_t e;
      m = margin;
      if (m < 1) m = 1;
      if (m > 3) m = 3;
      lines[(row_pos % SLOTS) * WIDTH + col_pos] = p;
      if (row_pos >= 2 * m && col_pos >= 2 * m) begin
        cr = row_pos - m;
        cc = col_pos - m;
        side = 2 * m + 1;
        sum = 0;
        for (int r = cr - m; r <= cr + m; r++)
          for (int c = cc - m; c <= cc + m; c++)
            sum += pix(r, c);
        thr = sum / (side * side) - int'($signed(offset));
        if (thr < int'(lmgb_pkg::THR_LOW)) thr = int'(lmgb_pkg::THR_LOW);
        if (thr > int'(lmgb_pkg::THR_HIGH)) thr = int'(lmgb_pkg::THR_HIGH);
        centre = pix(cr, cc);
        white = centre > thr + int'(lmgb_pkg::WHITE_GAP);
        if (centre > int'(lmgb_pkg::GLARE_LEVEL)) begin
          dark = 0;
          for (int r = cr - 1; r <= cr + 1; r++)
            for (int c = cc - 1; c <= cc + 1; c++)
              if (pix(r, c) < thr) dark++;
          white = dark < int'(lmgb_pkg::DARK_VOTES);
        end
        e.row = cr[5:0];
        e.col = cc[6:0];
        e.white = white;
        e.last = (row_pos == HEIGHT - 1 && col_pos == WIDTH - 1);
        pending.push_back(e);
      end
      if (col_pos + 1 >= WIDTH) begin
        col_pos = 0;
        row_pos = (row_pos + 1 >= HEIGHT) ? 0 : row_pos + 1;
      end else begin
        col_pos = col_pos + 1;
      end
    endfunction

    function void check_mark(logic [5:0] r, logic [6:0] c, logic w, logic l);
      mark_t e;
      if (pending.size() == 0) begin
        $error("result with nothing expected: row %0d col %0d", r, c);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (r !== e.row) begin
        $error("out_row expected %0d actual %0d", e.row, r);
        errors++;
      end
      if (c !== e.col) begin
        $error("out_col expected %0d actual %0d", e.col, c);
        errors++;
      end
      if (w !== e.white) begin
        $error("out_is_white expected %0d actual %0d", e.white, w);
        errors++;
      end
      if (l !== e.last) begin
        $error("out_frame_last expected %0d actual %0d", e.last, l);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_pixel = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [5:0] out_row;
  logic [6:0] out_col;
  logic       out_is_white;
  logic       out_frame_last;
  logic       cfg_we = 1'b0;
  logic       cfg_index = lmgb_pkg::REG_MARGIN;
  logic [8:0] cfg_data = 9'd0;

  glare_mark_board board = new();
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  int quiet = 0;
  int base_level = 128;

  always #5 clk = ~clk;

  local_mean_glare_binarizer u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_pixel(in_pixel),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_row(out_row), .out_col(out_col),
    .out_is_white(out_is_white), .out_frame_last(out_frame_last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) board.note_pixel(in_pixel);
      if (out_valid && out_ready)
        board.check_mark(out_row, out_col, out_is_white, out_frame_last);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 28);
      end
    end
  end

  task automatic write_reg(logic idx, logic [8:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == lmgb_pkg::REG_MARGIN) board.margin = val[1:0];
    else board.offset = val;
    @(posedge clk);
  endtask

  task automatic send_pixel(logic [7:0] p);
    in_valid <= 1'b1;
    in_pixel <= p;
    do @(posedge clk); while (!in_ready);
    if (!calm && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
  endtask

  function automatic logic [7:0] pick_pixel();
    int k, v;
    k = $urandom_range(99);
    if (k < 35) return 8'($urandom_range(255));
    if (k < 65) begin
      v = base_level + int'($urandom_range(40)) - 20;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return 8'(v);
    end
    if (k < 85) return 8'($urandom_range(255, 221));
    return 8'($urandom_range(40));
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  logic [7:0] directed [25] = '{8'd0, 8'd255, 8'h55, 8'hAA, 8'd0, 8'd255, 8'd221,
    8'd220, 8'd30, 8'd29, 8'd31, 8'd250, 8'd1, 8'd254, 8'h0F, 8'hF0, 8'd128,
    8'd127, 8'd255, 8'd255, 8'd0, 8'd0, 8'd240, 8'd10, 8'd60};
  logic [1:0] margins [16] = '{2'd1, 2'd3, 2'd2, 2'd0, 2'd3, 2'd1, 2'd2, 2'd3,
    2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd2, 2'd0, 2'd3};

  initial begin
    logic [8:0] off;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) send_pixel(directed[i]);
    drain();
    for (int ph = 0; ph < 16; ph++) begin
      case (ph)
        12: off = 9'd255;
        13: off = 9'h100;
        14: off = 9'd0;
        default: off = 9'($urandom_range(511));
      endcase
      write_reg(lmgb_pkg::REG_MARGIN, {7'd0, margins[ph]});
      write_reg(lmgb_pkg::REG_OFFSET, off);
      calm = (ph == 10);
      if (ph == 9) hold_req = 1'b1;
      for (int i = 0; i < 98; i++) begin
        if (i % 70 == 0) base_level = $urandom_range(255);
        send_pixel(pick_pixel());
      end
      drain();
    end
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
sv/lmgb_pkg.sv
sv/lmgb_divider.sv
sv/local_mean_glare_binarizer.sv
bench/tb_local_mean_glare_binarizer.sv
